/* hdl/ffe_pkg.sv */
// ---------------------------------------------------------------------------
// ffe_pkg: shared types and constants of the fire effect engine
// store geometry, command codes, register map, controller states and the
// command/status bundles between controller and datapath
// ---------------------------------------------------------------------------
package ffe_pkg;

	localparam int MAX_WIDTH     = 256;
	localparam int MAX_ROWS      = 128;
	localparam int PALETTE_DEPTH = 256;
	localparam int STORE_CELLS   = MAX_WIDTH * MAX_ROWS;
	localparam int ADDR_W        = $clog2(STORE_CELLS);
	localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

	localparam int HOT_VALUE   = 254;
	localparam int HIDDEN_ROWS = 3;
	localparam int TAP_COUNT   = 7;
	localparam int MIN_WIDTH   = 2;
	localparam int MIN_ROWS    = 4;

	// sum / 7 as (sum * DIV_MULT) >> DIV_SHIFT, exact for sums up to 7 * 255
	localparam int ACC_W     = 11;
	localparam int DIV_MULT  = 9363;
	localparam int DIV_SHIFT = 16;
	localparam int DIV_W     = ACC_W + 14;

	localparam logic [2:0] CMD_SRC = 3'd0;
	localparam logic [2:0] CMD_PAL = 3'd1;
	localparam logic [2:0] CMD_CLR = 3'd2;
	localparam logic [2:0] CMD_ADV = 3'd3;
	localparam logic [2:0] CMD_REN = 3'd4;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_ROWS   = 2'd1;
	localparam logic [1:0] REG_SOURCE = 2'd2;
	localparam logic [1:0] REG_ALPHA  = 2'd3;

	localparam logic [8:0] RST_WIDTH  = 9'd256;
	localparam logic [7:0] RST_ROWS   = 8'd128;
	localparam logic [6:0] RST_SOURCE = 7'd2;
	localparam logic [7:0] RST_ALPHA  = 8'd255;

	typedef enum logic [3:0] {
		ST_BOOT,
		ST_IDLE,
		ST_DISPATCH,
		ST_SRC_WR,
		ST_CLEAR,
		ST_ADV_COL,
		ST_ADV_RD,
		ST_ADV_LAST,
		ST_ADV_DIV,
		ST_ADV_WR,
		ST_REN_HEAT,
		ST_REN_PAL,
		ST_REN_BLEND,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [8:0] width_in_use;
		logic [7:0] rows_in_use;
		logic [6:0] source_row;
		logic [7:0] alpha;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic addr_calc;
		logic y_init;
		logic c_step;
		logic x_clr;
		logic x_inc;
		logic tap_rd;
		logic acc_clr;
		logic div;
		logic adv_wr;
		logic src_wr;
		logic pal_wr;
		logic clr_wr;
		logic heat_cap;
		logic blend;
		logic out_load;
	} ctrl_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       skip;
		logic       y_end;
		logic       x_end;
		logic       tap_last;
		logic       clr_last;
	} status_t;

endpackage

/* hdl/fire_effect_engine.sv */
// ---------------------------------------------------------------------------
// fire_effect_engine: fire effect heat store with palette render
// one item at a time; palette and unknown commands go from dispatch to finish,
// source adds a write; render runs accept, dispatch, heat read, palette read,
// blend, output load; clear sweeps the store; advance updates each cell above
// the source row column by column, none when no active row lies above it
// after reset a sweep over all 32768 cells zeroes the heat store with in_ready low
// ---------------------------------------------------------------------------
module fire_effect_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [7:0]  column,
	input  logic [6:0]  view_row,
	input  logic        hot,
	input  logic [7:0]  palette_index,
	input  logic [23:0] palette_colour,
	input  logic [7:0]  dest_c0,
	input  logic [7:0]  dest_c1,
	input  logic [7:0]  dest_c2,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_c0,
	output logic [7:0]  out_c1,
	output logic [7:0]  out_c2,
	output logic [7:0]  heat,
	output logic        done_res
);

	ffe_pkg::cfg_t    cfg_q;
	ffe_pkg::ctrl_t   ctrl;
	ffe_pkg::status_t status;
	logic             reg_wr;
	logic [1:0]       reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width_in_use <= ffe_pkg::RST_WIDTH;
			cfg_q.rows_in_use  <= ffe_pkg::RST_ROWS;
			cfg_q.source_row   <= ffe_pkg::RST_SOURCE;
			cfg_q.alpha        <= ffe_pkg::RST_ALPHA;
		end else if (reg_wr) begin
			unique case (reg_idx)
				ffe_pkg::REG_WIDTH:  cfg_q.width_in_use <= pwdata[8:0];
				ffe_pkg::REG_ROWS:   cfg_q.rows_in_use  <= pwdata[7:0];
				ffe_pkg::REG_SOURCE: cfg_q.source_row   <= pwdata[6:0];
				ffe_pkg::REG_ALPHA:  cfg_q.alpha        <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ffe_pkg::REG_WIDTH:  prdata = {23'd0, cfg_q.width_in_use};
			ffe_pkg::REG_ROWS:   prdata = {24'd0, cfg_q.rows_in_use};
			ffe_pkg::REG_SOURCE: prdata = {25'd0, cfg_q.source_row};
			ffe_pkg::REG_ALPHA:  prdata = {24'd0, cfg_q.alpha};
			default:             prdata = 32'd0;
		endcase
	end

	ffe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.ctrl      (ctrl)
	);

	ffe_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.ctrl           (ctrl),
		.status         (status),
		.command        (command),
		.column         (column),
		.view_row       (view_row),
		.hot            (hot),
		.palette_index  (palette_index),
		.palette_colour (palette_colour),
		.dest_c0        (dest_c0),
		.dest_c1        (dest_c1),
		.dest_c2        (dest_c2),
		.out_c0         (out_c0),
		.out_c1         (out_c1),
		.out_c2         (out_c2),
		.heat           (heat),
		.done_res       (done_res)
	);

	// an accepted item keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while previous one still in work");

	// a result of an unknown command carries nothing
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> out_c0 == 8'd0 && out_c1 == 8'd0 && out_c2 == 8'd0
			&& heat == 8'd0)
		else $error("result of unknown command not all zero");

	// a heat value shows only on a completed command
	a_heat_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && heat != 8'd0 |-> done_res)
		else $error("heat reported without done");

	// a new result is loaded only while the block is busy, never while idle
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> !in_ready)
		else $error("output loaded while idle");

endmodule

/* hdl/ffe_ram.sv */
// ---------------------------------------------------------------------------
// ffe_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module ffe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/ffe_ctrl.sv */
// ---------------------------------------------------------------------------
// ffe_ctrl: command sequencer of the fire effect engine
// boot clear sweep, command dispatch, frame advance walk, render steps
// and the output slot handshake
// ---------------------------------------------------------------------------
module ffe_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  ffe_pkg::status_t status,
	output ffe_pkg::ctrl_t   ctrl
);

	ffe_pkg::state_t state_q, state_nx;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ffe_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ffe_pkg::ST_BOOT: begin
				if (status.clr_last) state_nx = ffe_pkg::ST_IDLE;
			end
			ffe_pkg::ST_IDLE: begin
				if (in_valid) state_nx = ffe_pkg::ST_DISPATCH;
			end
			ffe_pkg::ST_DISPATCH: begin
				unique case (status.cmd)
					ffe_pkg::CMD_SRC: state_nx = ffe_pkg::ST_SRC_WR;
					ffe_pkg::CMD_CLR: state_nx = ffe_pkg::ST_CLEAR;
					ffe_pkg::CMD_ADV: state_nx = ffe_pkg::ST_ADV_COL;
					ffe_pkg::CMD_REN: state_nx = ffe_pkg::ST_REN_HEAT;
					default:          state_nx = ffe_pkg::ST_FINISH;
				endcase
			end
			ffe_pkg::ST_SRC_WR: state_nx = ffe_pkg::ST_FINISH;
			ffe_pkg::ST_CLEAR: begin
				if (status.clr_last) state_nx = ffe_pkg::ST_FINISH;
			end
			ffe_pkg::ST_ADV_COL: begin
				if (status.skip) state_nx = ffe_pkg::ST_FINISH;
				else state_nx = ffe_pkg::ST_ADV_RD;
			end
			ffe_pkg::ST_ADV_RD: begin
				if (status.tap_last) state_nx = ffe_pkg::ST_ADV_LAST;
			end
			ffe_pkg::ST_ADV_LAST: state_nx = ffe_pkg::ST_ADV_DIV;
			ffe_pkg::ST_ADV_DIV:  state_nx = ffe_pkg::ST_ADV_WR;
			ffe_pkg::ST_ADV_WR: begin
				priority if (status.y_end && status.x_end) state_nx = ffe_pkg::ST_FINISH;
				else if (status.y_end) state_nx = ffe_pkg::ST_ADV_COL;
				else state_nx = ffe_pkg::ST_ADV_RD;
			end
			ffe_pkg::ST_REN_HEAT:  state_nx = ffe_pkg::ST_REN_PAL;
			ffe_pkg::ST_REN_PAL:   state_nx = ffe_pkg::ST_REN_BLEND;
			ffe_pkg::ST_REN_BLEND: state_nx = ffe_pkg::ST_FINISH;
			ffe_pkg::ST_FINISH: begin
				if (slot_free) state_nx = ffe_pkg::ST_IDLE;
			end
			default: state_nx = ffe_pkg::ST_BOOT;
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ffe_pkg::ST_BOOT:  ctrl.clr_wr = 1'b1;
			ffe_pkg::ST_IDLE:  ctrl.capture = in_valid;
			ffe_pkg::ST_DISPATCH: begin
				unique case (status.cmd)
					ffe_pkg::CMD_SRC: ctrl.addr_calc = 1'b1;
					ffe_pkg::CMD_PAL: ctrl.pal_wr = 1'b1;
					ffe_pkg::CMD_ADV: ctrl.x_clr = 1'b1;
					ffe_pkg::CMD_REN: ctrl.addr_calc = 1'b1;
					default: ;
				endcase
			end
			ffe_pkg::ST_SRC_WR: ctrl.src_wr = 1'b1;
			ffe_pkg::ST_CLEAR:  ctrl.clr_wr = 1'b1;
			ffe_pkg::ST_ADV_COL: begin
				ctrl.addr_calc = 1'b1;
				ctrl.y_init    = 1'b1;
				ctrl.acc_clr   = 1'b1;
			end
			ffe_pkg::ST_ADV_RD:   ctrl.tap_rd = 1'b1;
			ffe_pkg::ST_ADV_LAST: ;
			ffe_pkg::ST_ADV_DIV: begin
				ctrl.div     = 1'b1;
				ctrl.acc_clr = 1'b1;
			end
			ffe_pkg::ST_ADV_WR: begin
				ctrl.adv_wr = 1'b1;
				ctrl.x_inc  = status.y_end;
				ctrl.c_step = !status.y_end;
			end
			ffe_pkg::ST_REN_HEAT:  ;
			ffe_pkg::ST_REN_PAL:   ctrl.heat_cap = 1'b1;
			ffe_pkg::ST_REN_BLEND: ctrl.blend = 1'b1;
			ffe_pkg::ST_FINISH:    ctrl.out_load = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffe_pkg::ST_BOOT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctrl.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

/* hdl/ffe_datapath.sv */
// ---------------------------------------------------------------------------
// ffe_datapath: heat store, palette and arithmetic of the fire effect engine
// item capture, address unit, seven-tap accumulator with divide by seven,
// clear sweep counter, palette lookup, alpha blend and the output register
// ---------------------------------------------------------------------------
module ffe_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  ffe_pkg::cfg_t       cfg,
	input  ffe_pkg::ctrl_t      ctrl,
	output ffe_pkg::status_t    status,
	input  logic [2:0]          command,
	input  logic [7:0]          column,
	input  logic [6:0]          view_row,
	input  logic                hot,
	input  logic [7:0]          palette_index,
	input  logic [23:0]         palette_colour,
	input  logic [7:0]          dest_c0,
	input  logic [7:0]          dest_c1,
	input  logic [7:0]          dest_c2,
	output logic [7:0]          out_c0,
	output logic [7:0]          out_c1,
	output logic [7:0]          out_c2,
	output logic [7:0]          heat,
	output logic                done_res
);

	localparam int AW = ffe_pkg::ADDR_W;

	function automatic logic [7:0] blend(input logic [7:0] colour, input logic [7:0] dest,
		input logic [7:0] a);
		logic [16:0] s;
		s = 17'(colour) * 17'(a) + 17'(dest) * (17'd256 - 17'(a));
		return s[15:8];
	endfunction

	// captured item
	logic [2:0]  cmd_q;
	logic [7:0]  column_q;
	logic [6:0]  view_row_q;
	logic        hot_q;
	logic [7:0]  pidx_q;
	logic [23:0] pcolour_q;
	logic [7:0]  dest0_q, dest1_q, dest2_q;

	// effective geometry
	logic [8:0] w_eff;
	logic [7:0] h_eff;
	logic [6:0] s_eff;

	// address unit
	logic [7:0]  row_op;
	logic [8:0]  col_op;
	logic [17:0] addr_full;
	logic [AW-1:0] addr_q;
	logic        ok_q;
	logic [8:0]  x_q;
	logic [7:0]  y_q;
	logic [2:0]  tap_q;
	logic [AW-1:0] tap_off;

	// accumulator and divider
	logic [ffe_pkg::ACC_W-1:0] acc_q;
	logic                      acc_en_s1;
	logic [ffe_pkg::DIV_W-1:0] div_prod;
	logic [7:0]                q_q;

	// clear sweep
	logic [AW-1:0] clr_cnt_q;

	// heat store and palette ports
	logic          heat_we;
	logic [AW-1:0] heat_waddr, heat_raddr;
	logic [7:0]    heat_wdata, heat_rdata;
	logic [23:0]   pal_rdata;

	// render results
	logic [7:0] heat_q;
	logic [7:0] res0_q, res1_q, res2_q, resh_q;

	always_comb begin
		if (cfg.width_in_use < 9'(ffe_pkg::MIN_WIDTH)) w_eff = 9'(ffe_pkg::MIN_WIDTH);
		else if (cfg.width_in_use > 9'(ffe_pkg::MAX_WIDTH)) w_eff = 9'(ffe_pkg::MAX_WIDTH);
		else w_eff = cfg.width_in_use;
		if (cfg.rows_in_use < 8'(ffe_pkg::MIN_ROWS)) h_eff = 8'(ffe_pkg::MIN_ROWS);
		else if (cfg.rows_in_use > 8'(ffe_pkg::MAX_ROWS)) h_eff = 8'(ffe_pkg::MAX_ROWS);
		else h_eff = cfg.rows_in_use;
		s_eff = (cfg.source_row == 7'd0) ? 7'd1 : cfg.source_row;
	end

	always_comb begin
		unique case (cmd_q)
			ffe_pkg::CMD_SRC: begin
				row_op = {1'b0, cfg.source_row};
				col_op = {1'b0, column_q};
			end
			ffe_pkg::CMD_REN: begin
				row_op = {1'b0, view_row_q} + 8'(ffe_pkg::HIDDEN_ROWS);
				col_op = {1'b0, column_q};
			end
			default: begin
				row_op = {1'b0, s_eff};
				col_op = x_q;
			end
		endcase
		addr_full = 18'(row_op) * 18'(w_eff) + 18'(col_op);
	end

	always_comb begin
		unique case (tap_q)
			3'd0:    tap_off = AW'(w_eff);
			3'd1:    tap_off = AW'(0) - AW'(w_eff);
			3'd2:    tap_off = AW'(1);
			3'd3:    tap_off = AW'(0) - AW'(1);
			3'd4:    tap_off = AW'(2);
			3'd5:    tap_off = AW'(0) - AW'(2);
			default: tap_off = AW'(0);
		endcase
	end

	assign heat_raddr = ctrl.tap_rd ? addr_q + tap_off : addr_q;
	assign heat_we    = ctrl.clr_wr || ctrl.adv_wr || (ctrl.src_wr && ok_q);

	always_comb begin
		priority if (ctrl.clr_wr) begin
			heat_waddr = clr_cnt_q;
			heat_wdata = 8'd0;
		end else if (ctrl.src_wr) begin
			heat_waddr = addr_q;
			heat_wdata = hot_q ? 8'(ffe_pkg::HOT_VALUE) : 8'd0;
		end else begin
			heat_waddr = addr_q + AW'(w_eff);
			heat_wdata = q_q;
		end
	end

	assign div_prod = ffe_pkg::DIV_W'(acc_q) * ffe_pkg::DIV_W'(ffe_pkg::DIV_MULT);

	ffe_ram #(
		.WIDTH(8),
		.DEPTH(ffe_pkg::STORE_CELLS)
	) u_heat_ram (
		.clk   (clk),
		.we    (heat_we),
		.waddr (heat_waddr),
		.wdata (heat_wdata),
		.raddr (heat_raddr),
		.rdata (heat_rdata)
	);

	ffe_ram #(
		.WIDTH(24),
		.DEPTH(ffe_pkg::PALETTE_DEPTH)
	) u_pal_ram (
		.clk   (clk),
		.we    (ctrl.pal_wr),
		.waddr (pidx_q[ffe_pkg::PAL_AW-1:0]),
		.wdata (pcolour_q),
		.raddr (heat_rdata[ffe_pkg::PAL_AW-1:0]),
		.rdata (pal_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q     <= 3'd0;
			acc_en_s1 <= 1'b0;
			clr_cnt_q <= '0;
		end else begin
			acc_en_s1 <= ctrl.tap_rd;
			if (ctrl.tap_rd) begin
				tap_q <= (tap_q == 3'(ffe_pkg::TAP_COUNT - 1)) ? 3'd0 : tap_q + 3'd1;
			end
			if (ctrl.clr_wr) clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q      <= command;
			column_q   <= column;
			view_row_q <= view_row;
			hot_q      <= hot;
			pidx_q     <= palette_index;
			pcolour_q  <= palette_colour;
			dest0_q    <= dest_c0;
			dest1_q    <= dest_c1;
			dest2_q    <= dest_c2;
		end
		if (ctrl.addr_calc) begin
			addr_q <= addr_full[AW-1:0];
			ok_q   <= (col_op < w_eff) && (row_op < h_eff);
		end else if (ctrl.c_step) begin
			addr_q <= addr_q + AW'(w_eff);
		end
		if (ctrl.x_clr) x_q <= 9'd0;
		else if (ctrl.x_inc) x_q <= x_q + 9'd1;
		if (ctrl.y_init) y_q <= {1'b0, s_eff};
		else if (ctrl.c_step) y_q <= y_q + 8'd1;
		if (ctrl.acc_clr) acc_q <= '0;
		else if (acc_en_s1) acc_q <= acc_q + ffe_pkg::ACC_W'(heat_rdata);
		if (ctrl.div) q_q <= div_prod[ffe_pkg::DIV_SHIFT +: 8];
		if (ctrl.heat_cap) heat_q <= heat_rdata;
		if (ctrl.blend) begin
			if (ok_q) begin
				res0_q <= blend(pal_rdata[7:0], dest0_q, cfg.alpha);
				res1_q <= blend(pal_rdata[15:8], dest1_q, cfg.alpha);
				res2_q <= blend(pal_rdata[23:16], dest2_q, cfg.alpha);
				resh_q <= heat_q;
			end else begin
				res0_q <= dest0_q;
				res1_q <= dest1_q;
				res2_q <= dest2_q;
				resh_q <= 8'd0;
			end
		end
		if (ctrl.out_load) begin
			unique case (cmd_q)
				ffe_pkg::CMD_REN: begin
					out_c0   <= res0_q;
					out_c1   <= res1_q;
					out_c2   <= res2_q;
					heat     <= resh_q;
					done_res <= 1'b1;
				end
				ffe_pkg::CMD_SRC, ffe_pkg::CMD_PAL, ffe_pkg::CMD_CLR, ffe_pkg::CMD_ADV: begin
					out_c0   <= 8'd0;
					out_c1   <= 8'd0;
					out_c2   <= 8'd0;
					heat     <= 8'd0;
					done_res <= 1'b1;
				end
				default: begin
					out_c0   <= 8'd0;
					out_c1   <= 8'd0;
					out_c2   <= 8'd0;
					heat     <= 8'd0;
					done_res <= 1'b0;
				end
			endcase
		end
	end

	assign status.cmd      = cmd_q;
	assign status.skip     = ({1'b0, s_eff} + 8'd1) >= h_eff;
	assign status.y_end    = ({1'b0, y_q} + 9'd2) == {1'b0, h_eff};
	assign status.x_end    = ({1'b0, x_q} + 10'd1) == {1'b0, w_eff};
	assign status.tap_last = (tap_q == 3'(ffe_pkg::TAP_COUNT - 1));
	assign status.clr_last = (clr_cnt_q == AW'(ffe_pkg::STORE_CELLS - 1));

endmodule

/* dv/fire_effect_engine_tb.sv */
// ---------------------------------------------------------------------------
// fire_effect_engine_tb: self-checking bench for the fire effect engine
// a local copy of the heat store, palette and registers predicts every
// command's result as it is queued; a driver and a monitor move items over
// valid/ready with random gaps and stalls, and each result is checked field
// by field; registers change over APB between phases, once the engine drains
// ---------------------------------------------------------------------------
module fire_effect_engine_tb;
	import ffe_pkg::*;

	localparam logic [2:0] CMD_FIRST_UNUSED = CMD_REN + 3'd1;

	typedef struct {
		logic [2:0]  command;
		logic [7:0]  column;
		logic [6:0]  view_row;
		logic        hot;
		logic [7:0]  palette_index;
		logic [23:0] palette_colour;
		logic [7:0]  dest_c0;
		logic [7:0]  dest_c1;
		logic [7:0]  dest_c2;
	} cmd_item_t;

	typedef struct {
		logic [7:0] out_c0;
		logic [7:0] out_c1;
		logic [7:0] out_c2;
		logic [7:0] heat;
		logic       done_res;
	} pixel_res_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  command = '0;
	logic [7:0]  column = '0;
	logic [6:0]  view_row = '0;
	logic        hot = 1'b0;
	logic [7:0]  palette_index = '0;
	logic [23:0] palette_colour = '0;
	logic [7:0]  dest_c0 = '0;
	logic [7:0]  dest_c1 = '0;
	logic [7:0]  dest_c2 = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_c0;
	logic [7:0]  out_c1;
	logic [7:0]  out_c2;
	logic [7:0]  heat;
	logic        done_res;

	fire_effect_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.column(column),
		.view_row(view_row),
		.hot(hot),
		.palette_index(palette_index),
		.palette_colour(palette_colour),
		.dest_c0(dest_c0),
		.dest_c1(dest_c1),
		.dest_c2(dest_c2),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_c0(out_c0),
		.out_c1(out_c1),
		.out_c2(out_c2),
		.heat(heat),
		.done_res(done_res)
	);

	// mirror of the engine state
	logic [7:0]  heat_mem [STORE_CELLS];
	logic [23:0] colour_lut [PALETTE_DEPTH];
	bit          lut_loaded [PALETTE_DEPTH];
	cfg_t        regs;

	cmd_item_t  cmd_backlog[$];
	pixel_res_t backlog_results[$];
	pixel_res_t results_due[$];

	int mismatch_count = 0;
	int clears_left = 4;
	int feed_gap, feed_calm = 0;
	int drain_stall, drain_calm = 0;
	logic next_valid, next_ready;

	function automatic int eff_width();
		int w;
		w = regs.width_in_use;
		if (w < MIN_WIDTH) w = MIN_WIDTH;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int eff_rows();
		int h;
		h = regs.rows_in_use;
		if (h < MIN_ROWS) h = MIN_ROWS;
		if (h > MAX_ROWS) h = MAX_ROWS;
		return h;
	endfunction

	function automatic int eff_source();
		return (regs.source_row < 1) ? 1 : int'(regs.source_row);
	endfunction

	function automatic int cell_at(int addr);
		return (addr >= 0 && addr < STORE_CELLS) ? int'(heat_mem[addr]) : 0;
	endfunction

	// in-place update, column by column, rising from the source row
	function automatic void advance_heat();
		int w, h, s, c, total;
		w = eff_width();
		h = eff_rows();
		s = eff_source();
		for (int x = 0; x < w; x++) begin
			for (int y = s; y < h - 1; y++) begin
				c = y * w + x;
				total = cell_at(c + w) + cell_at(c - w) + cell_at(c + 1) + cell_at(c - 1)
					+ cell_at(c + 2) + cell_at(c - 2) + cell_at(c);
				if (c + w < STORE_CELLS) heat_mem[c + w] = 8'(total / TAP_COUNT);
			end
		end
	endfunction

	function automatic logic [7:0] mix_channel(int fire, int dest, int weight);
		return 8'((fire * weight + dest * (256 - weight)) >> 8);
	endfunction

	function automatic pixel_res_t predict_command(cmd_item_t it);
		pixel_res_t r;
		int w, h, row, hv;
		logic [23:0] c;
		w = eff_width();
		h = eff_rows();
		r = '{default: '0};
		case (it.command)
			CMD_SRC: begin
				if (it.column < w && regs.source_row < h)
					heat_mem[int'(regs.source_row) * w + it.column] =
						it.hot ? 8'(HOT_VALUE) : 8'd0;
				r.done_res = 1'b1;
			end
			CMD_PAL: begin
				colour_lut[it.palette_index] = it.palette_colour;
				lut_loaded[it.palette_index] = 1'b1;
				r.done_res = 1'b1;
			end
			CMD_CLR: begin
				foreach (heat_mem[i]) heat_mem[i] = '0;
				r.done_res = 1'b1;
			end
			CMD_ADV: begin
				advance_heat();
				r.done_res = 1'b1;
			end
			CMD_REN: begin
				row = it.view_row + HIDDEN_ROWS;
				if (it.column < w && row < h) begin
					hv = heat_mem[row * w + it.column];
					c = colour_lut[hv];
					r.out_c0 = mix_channel(c[7:0], it.dest_c0, regs.alpha);
					r.out_c1 = mix_channel(c[15:8], it.dest_c1, regs.alpha);
					r.out_c2 = mix_channel(c[23:16], it.dest_c2, regs.alpha);
					r.heat = 8'(hv);
				end else begin
					r.out_c0 = it.dest_c0;
					r.out_c1 = it.dest_c1;
					r.out_c2 = it.dest_c2;
				end
				r.done_res = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic cmd_item_t random_item();
		cmd_item_t it;
		it.command = 3'($urandom);
		it.column = 8'($urandom);
		it.view_row = 7'($urandom);
		it.hot = 1'($urandom);
		it.palette_index = 8'($urandom);
		it.palette_colour = 24'($urandom);
		it.dest_c0 = 8'($urandom);
		it.dest_c1 = 8'($urandom);
		it.dest_c2 = 8'($urandom);
		return it;
	endfunction

	function automatic cmd_item_t pick_item(logic [2:0] op, int col, int vrow, bit hot_bit);
		cmd_item_t it;
		it = random_item();
		it.command = op;
		it.column = 8'(col);
		it.view_row = 7'(vrow);
		it.hot = hot_bit;
		return it;
	endfunction

	function automatic int draw_wait(ref int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 7) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	task automatic push_predicted(cmd_item_t it);
		cmd_backlog.push_back(it);
		backlog_results.push_back(predict_command(it));
	endtask

	// a render never goes through a palette entry that was never loaded
	task automatic queue_item(cmd_item_t it);
		cmd_item_t fix;
		int w, row, hv;
		w = eff_width();
		row = it.view_row + HIDDEN_ROWS;
		if (it.command == CMD_REN && it.column < w && row < eff_rows()) begin
			hv = heat_mem[row * w + it.column];
			if (!lut_loaded[hv]) begin
				fix = random_item();
				fix.command = CMD_PAL;
				fix.palette_index = 8'(hv);
				push_predicted(fix);
			end
		end
		push_predicted(it);
	endtask

	task automatic queue_random();
		cmd_item_t it;
		int pick, w, h;
		it = random_item();
		w = eff_width();
		h = eff_rows();
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			it.command = CMD_SRC;
			if ($urandom_range(0, 4) != 0) it.column = 8'($urandom_range(0, w - 1));
			it.hot = ($urandom_range(0, 3) != 0);
		end else if (pick < 65) begin
			it.command = CMD_REN;
			if ($urandom_range(0, 6) != 0) begin
				it.column = 8'($urandom_range(0, w - 1));
				it.view_row = 7'($urandom_range(0, h - 4));
			end
		end else if (pick < 77) begin
			it.command = CMD_PAL;
		end else if (pick < 89) begin
			it.command = CMD_ADV;
		end else if (pick < 91) begin
			it.command = (clears_left > 0) ? CMD_CLR : CMD_PAL;
			if (clears_left > 0) clears_left--;
		end else if (pick < 96) begin
			it.command = CMD_FIRST_UNUSED + 3'($urandom_range(0, 2));
		end else begin
			it.command = CMD_SRC;
		end
		queue_item(it);
	endtask

	task automatic wait_idle();
		while (cmd_backlog.size() != 0 || results_due.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_WIDTH:  regs.width_in_use = data[8:0];
			REG_ROWS:   regs.rows_in_use = data[7:0];
			REG_SOURCE: regs.source_row = data[6:0];
			REG_ALPHA:  regs.alpha = data[7:0];
		endcase
	endtask

	// upper bits of each write are junk and must be dropped
	task automatic set_config(int w, int h, int s, int a);
		apb_write(REG_WIDTH, {23'($urandom), 9'(w)});
		apb_write(REG_ROWS, {24'($urandom), 8'(h)});
		apb_write(REG_SOURCE, {25'($urandom), 7'(s)});
		apb_write(REG_ALPHA, {24'($urandom), 8'(a)});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic void check_field(string label, int want, int got);
		if (want != got) begin
			$display("%0t %s expected %0d actual %0d", $time, label, want, got);
			mismatch_count++;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#60000000;
		$display("Mismatches found");
		$finish;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			feed_gap = draw_wait(feed_calm);
		end else begin
			next_valid = in_valid;
			if (in_valid && in_ready) begin
				results_due.push_back(backlog_results.pop_front());
				void'(cmd_backlog.pop_front());
				feed_gap = draw_wait(feed_calm);
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (feed_gap > 0) begin
					feed_gap--;
				end else if (cmd_backlog.size() > 0) begin
					command <= cmd_backlog[0].command;
					column <= cmd_backlog[0].column;
					view_row <= cmd_backlog[0].view_row;
					hot <= cmd_backlog[0].hot;
					palette_index <= cmd_backlog[0].palette_index;
					palette_colour <= cmd_backlog[0].palette_colour;
					dest_c0 <= cmd_backlog[0].dest_c0;
					dest_c1 <= cmd_backlog[0].dest_c1;
					dest_c2 <= cmd_backlog[0].dest_c2;
					next_valid = 1'b1;
				end
			end
			in_valid <= next_valid;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			drain_stall = draw_wait(drain_calm);
		end else begin
			next_ready = out_ready;
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$display("%0t unexpected item: expected none actual heat %0d done %0d",
						$time, heat, done_res);
					mismatch_count++;
				end else begin
					pixel_res_t want;
					want = results_due.pop_front();
					check_field("out_c0", want.out_c0, out_c0);
					check_field("out_c1", want.out_c1, out_c1);
					check_field("out_c2", want.out_c2, out_c2);
					check_field("heat", want.heat, heat);
					check_field("done_res", want.done_res, done_res);
				end
				drain_stall = draw_wait(drain_calm);
				next_ready = (drain_stall == 0);
			end else if (!out_ready) begin
				if (drain_stall > 0) drain_stall--;
				next_ready = (drain_stall == 0);
			end
			out_ready <= next_ready;
		end
	end

	initial begin : stimulus
		cmd_item_t it;
		int w, h, s;
		regs = {RST_WIDTH, RST_ROWS, RST_SOURCE, RST_ALPHA};
		foreach (heat_mem[i]) heat_mem[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: palette extremes, source and render corners
		it = pick_item(CMD_PAL, 0, 0, 0);
		it.palette_index = 8'd0;
		it.palette_colour = 24'h000000;
		queue_item(it);
		it = pick_item(CMD_PAL, 0, 0, 0);
		it.palette_index = 8'd255;
		it.palette_colour = 24'hFFFFFF;
		queue_item(it);
		it = pick_item(CMD_PAL, 0, 0, 0);
		it.palette_index = 8'(HOT_VALUE);
		queue_item(it);
		queue_item(pick_item(CMD_SRC, 0, 0, 1));
		queue_item(pick_item(CMD_SRC, 255, 0, 1));
		queue_item(pick_item(CMD_SRC, 7, 0, 0));
		it = pick_item(CMD_REN, 0, 0, 0);
		it.dest_c0 = 8'hFF;
		it.dest_c1 = 8'hFF;
		it.dest_c2 = 8'hFF;
		queue_item(it);
		it = pick_item(CMD_REN, 255, 124, 0);
		it.dest_c0 = 8'h00;
		it.dest_c1 = 8'h00;
		it.dest_c2 = 8'h00;
		queue_item(it);
		queue_item(pick_item(CMD_REN, 3, 125, 0));
		queue_item(pick_item(CMD_REN, 255, 127, 0));
		for (int k = 0; k < 3; k++)
			queue_item(pick_item(CMD_FIRST_UNUSED + 3'(k), 0, 0, 0));
		queue_item(pick_item(CMD_CLR, 0, 0, 0));
		wait_idle();

		// full size, source on the second-to-last row, alpha zero
		set_config(256, 128, 126, 0);
		queue_item(pick_item(CMD_SRC, 0, 0, 1));
		queue_item(pick_item(CMD_SRC, 255, 0, 1));
		queue_item(pick_item(CMD_ADV, 0, 0, 0));
		queue_item(pick_item(CMD_REN, 0, 124, 0));
		queue_item(pick_item(CMD_REN, 1, 124, 0));
		wait_idle();

		// smallest geometry, edge cells wrap into the next row
		set_config(2, 4, 1, 255);
		queue_item(pick_item(CMD_SRC, 0, 0, 1));
		queue_item(pick_item(CMD_SRC, 1, 0, 1));
		queue_item(pick_item(CMD_SRC, 2, 0, 1));
		queue_item(pick_item(CMD_ADV, 0, 0, 0));
		queue_item(pick_item(CMD_REN, 0, 0, 0));
		queue_item(pick_item(CMD_REN, 2, 0, 0));
		queue_item(pick_item(CMD_REN, 0, 1, 0));
		wait_idle();

		for (int k = 0; k < 10; k++) begin
			case (k)
				0: set_config(2, 4, 1, 0);
				1: set_config(0, 0, 0, 128);
				2: set_config(1, 3, 0, 255);
				3: set_config(511, 255, 127, $urandom_range(0, 255));
				4: set_config(300, 200, 125, $urandom_range(0, 255));
				5: set_config(256, 128, 124, $urandom_range(0, 255));
				7: begin
					w = $urandom_range(200, 256);
					h = $urandom_range(4, 6);
					set_config(w, h, $urandom_range(1, h - 2), $urandom_range(0, 255));
				end
				default: begin
					w = $urandom_range(2, 24);
					h = $urandom_range(4, 16);
					s = $urandom_range(1, h - 1);
					set_config(w, h, s, $urandom_range(0, 255));
				end
			endcase
			repeat (40) queue_random();
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && results_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
hdl/ffe_pkg.sv
hdl/ffe_ram.sv
hdl/ffe_ctrl.sv
hdl/ffe_datapath.sv
hdl/fire_effect_engine.sv
dv/fire_effect_engine_tb.sv
